>>> rtl/core/nwa_pkg.sv
// ----------------------------------------------------------------------------
// nwa_pkg
// Shared types and constants for the NFA word acceptor.
// ----------------------------------------------------------------------------
package nwa_pkg;

  localparam int unsigned NUM_STATES  = 16;
  localparam int unsigned ALPHABET    = 256;
  localparam int unsigned STATE_W     = $clog2(NUM_STATES);
  localparam int unsigned SYMBOL_W    = $clog2(ALPHABET);
  localparam int unsigned FUNC_W      = 2;
  localparam int unsigned TABLE_DEPTH = NUM_STATES * ALPHABET;
  localparam int unsigned TABLE_AW    = $clog2(TABLE_DEPTH);
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = NUM_STATES;

  typedef logic [NUM_STATES-1:0] state_set_t;
  typedef logic [STATE_W-1:0]    state_idx_t;
  typedef logic [SYMBOL_W-1:0]   symbol_t;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ADD    = 2'd0,
    FUNC_START  = 2'd1,
    FUNC_SYMBOL = 2'd2
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INITIAL_STATE = 1'b0,
    CFG_FINAL_MASK    = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic capture;
    logic clr_write;
    logic add_read;
    logic add_write;
    logic scan_issue;
    logic commit;
  } nwa_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic scan_last;
    logic out_free;
  } nwa_status_t;

endpackage

>>> rtl/core/nfa_word_acceptor_unit.sv
// ----------------------------------------------------------------------------
// nfa_word_acceptor_unit
// Subset simulation of a 16-state NFA over a 256-symbol alphabet.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o) carries one command per transaction:
// add a transition, start a new word, or feed one symbol. Every transaction
// returns exactly one result on the output channel (out_valid_o / out_stall_i):
// the active set, whether it meets the final mask, and whether it is empty.
// Configuration (cfg_valid_i / cfg_ready_o): index 0 initial state, index 1
// final mask; write only while the unit is idle.
// Steps per command: start word goes straight to report; add transition does a
// read-modify-write of one table row, then reports; feed symbol reads one table
// row per state over the single read port of the transition RAM, then takes one
// drain and one report step. One command is processed at a time; the next one
// is taken the cycle after the result register is loaded.
// Reset: a clearing pass writes zero to all 4096 table rows, one per cycle;
// the input channel stalls until the pass is done. The active set resets to
// state 0 alone. If the receiver stalls, the result register holds and a
// finished command waits in its report step until the register frees.
// ----------------------------------------------------------------------------
module nfa_word_acceptor_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [nwa_pkg::FUNC_W-1:0]     in_func_i,
  input  logic [nwa_pkg::SYMBOL_W-1:0]   in_symbol_i,
  input  logic [nwa_pkg::STATE_W-1:0]    in_source_state_i,
  input  logic [nwa_pkg::STATE_W-1:0]    in_dest_state_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [nwa_pkg::NUM_STATES-1:0] out_active_set_o,
  output logic                           out_accepted_o,
  output logic                           out_dead_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [nwa_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [nwa_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import nwa_pkg::*;

  nwa_cmd_t    cmd;
  nwa_status_t status;

  assign cfg_ready_o = 1'b1;

  nwa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_func_i  (in_func_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  nwa_dpath u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .in_func_i         (in_func_i),
    .in_symbol_i       (in_symbol_i),
    .in_source_state_i (in_source_state_i),
    .in_dest_state_i   (in_dest_state_i),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .out_stall_i       (out_stall_i),
    .out_valid_o       (out_valid_o),
    .out_active_set_o  (out_active_set_o),
    .out_accepted_o    (out_accepted_o),
    .out_dead_o        (out_dead_o)
  );

  a_clear_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clr_write |-> in_stall_o)
    else $error("input accepted during table clear");

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.clr_write, cmd.add_read, cmd.add_write, cmd.scan_issue, cmd.commit}))
    else $error("conflicting datapath commands");

  a_commit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |=> out_valid_o)
    else $error("committed result not presented");

  a_dead_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_dead_o == (out_active_set_o == '0)))
    else $error("dead flag disagrees with active set");

endmodule

>>> rtl/core/nwa_ram.sv
// ----------------------------------------------------------------------------
// nwa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module nwa_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

>>> rtl/core/nwa_ctrl.sv
// ----------------------------------------------------------------------------
// nwa_ctrl
// Sequencer: table clear after reset, transition insert, symbol scan, report.
// ----------------------------------------------------------------------------
module nwa_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic [nwa_pkg::FUNC_W-1:0] in_func_i,
  output logic                      in_stall_o,
  input  nwa_pkg::nwa_status_t      status_i,
  output nwa_pkg::nwa_cmd_t         cmd_o
);
  import nwa_pkg::*;

  typedef enum logic [6:0] {
    ST_CLEAR  = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_ADD_RD = 7'b0000100,
    ST_ADD_WR = 7'b0001000,
    ST_SCAN   = 7'b0010000,
    ST_DRAIN  = 7'b0100000,
    ST_REPORT = 7'b1000000
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;
  logic        accept;

  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_write = 1'b1;
        if (status_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          cmd_o.capture = 1'b1;
          unique case (in_func_i)
            FUNC_ADD:    state_d = ST_ADD_RD;
            FUNC_SYMBOL: state_d = ST_SCAN;
            default:     state_d = ST_REPORT;
          endcase
        end
      end
      ST_ADD_RD: begin
        cmd_o.add_read = 1'b1;
        state_d        = ST_ADD_WR;
      end
      ST_ADD_WR: begin
        cmd_o.add_write = 1'b1;
        state_d         = ST_REPORT;
      end
      ST_SCAN: begin
        cmd_o.scan_issue = 1'b1;
        if (status_i.scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_REPORT;
      end
      ST_REPORT: begin
        if (status_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/core/nwa_dpath.sv
// ----------------------------------------------------------------------------
// nwa_dpath
// Transition table, active set, scan accumulator, configuration and output.
// ----------------------------------------------------------------------------
module nwa_dpath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  nwa_pkg::nwa_cmd_t             cmd_i,
  output nwa_pkg::nwa_status_t          status_o,
  input  logic [nwa_pkg::FUNC_W-1:0]    in_func_i,
  input  logic [nwa_pkg::SYMBOL_W-1:0]  in_symbol_i,
  input  logic [nwa_pkg::STATE_W-1:0]   in_source_state_i,
  input  logic [nwa_pkg::STATE_W-1:0]   in_dest_state_i,
  input  logic                          cfg_valid_i,
  input  logic [nwa_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [nwa_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                          out_stall_i,
  output logic                          out_valid_o,
  output logic [nwa_pkg::NUM_STATES-1:0] out_active_set_o,
  output logic                          out_accepted_o,
  output logic                          out_dead_o
);
  import nwa_pkg::*;

  func_e      func_q;
  symbol_t    sym_q;
  state_idx_t src_q, dst_q;

  state_idx_t init_q;
  state_set_t final_mask_q;
  state_set_t active_q, active_d;
  state_set_t acc_q;

  logic [TABLE_AW-1:0] clr_cnt_q;
  state_idx_t          scan_cnt_q;
  logic                rd_scan_q;
  logic                rd_act_q;

  logic                ram_we, ram_re;
  logic [TABLE_AW-1:0] ram_waddr, ram_raddr;
  state_set_t          ram_wdata, ram_rdata;

  logic       out_valid_q;
  state_set_t out_set_q;
  logic       out_acc_q, out_dead_q;

  assign status_o.clr_last  = &clr_cnt_q;
  assign status_o.scan_last = &scan_cnt_q;
  assign status_o.out_free  = !out_valid_q || !out_stall_i;

  assign ram_we    = cmd_i.clr_write || cmd_i.add_write;
  assign ram_waddr = cmd_i.clr_write ? clr_cnt_q : {src_q, sym_q};
  assign ram_wdata = cmd_i.clr_write ? '0 : (ram_rdata | (state_set_t'(1) << dst_q));
  assign ram_re    = cmd_i.add_read || cmd_i.scan_issue;
  assign ram_raddr = cmd_i.scan_issue ? {scan_cnt_q, sym_q} : {src_q, sym_q};

  nwa_ram #(
    .WIDTH (NUM_STATES),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q <= func_e'(in_func_i);
      sym_q  <= in_symbol_i;
      src_q  <= in_source_state_i;
      dst_q  <= in_dest_state_i;
    end
  end

  always_comb begin
    unique case (func_q)
      FUNC_SYMBOL: active_d = acc_q;
      FUNC_START:  active_d = state_set_t'(1) << init_q;
      default:     active_d = active_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q       <= '0;
      final_mask_q <= '0;
      active_q     <= state_set_t'(1);
      acc_q        <= '0;
      clr_cnt_q    <= '0;
      scan_cnt_q   <= '0;
      rd_scan_q    <= 1'b0;
      rd_act_q     <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_INITIAL_STATE: init_q       <= cfg_data_i[STATE_W-1:0];
          CFG_FINAL_MASK:    final_mask_q <= cfg_data_i;
        endcase
      end
      if (cmd_i.clr_write) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
      rd_scan_q <= cmd_i.scan_issue;
      rd_act_q  <= active_q[scan_cnt_q];
      if (cmd_i.capture) begin
        acc_q      <= '0;
        scan_cnt_q <= '0;
      end else begin
        if (cmd_i.scan_issue) begin
          scan_cnt_q <= scan_cnt_q + 1'b1;
        end
        if (rd_scan_q && rd_act_q) begin
          acc_q <= acc_q | ram_rdata;
        end
      end
      if (cmd_i.commit) begin
        active_q    <= active_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_set_q  <= active_d;
      out_acc_q  <= |(active_d & final_mask_q);
      out_dead_q <= (active_d == '0);
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_active_set_o = out_set_q;
  assign out_accepted_o   = out_acc_q;
  assign out_dead_o       = out_dead_q;

endmodule

>>> bench/tb_nfa_word_acceptor_unit.sv
// ----------------------------------------------------------------------------
// tb_nfa_word_acceptor_unit
// Self-checking bench for the NFA word acceptor. A directed table walks the
// reset state, the extreme states and symbols, duplicate transitions, unused
// command codes, dead words and both registers at their extremes. Random
// phases then build small automata over a few working symbols, run
// well-formed words through them, and mix in noise. Every result is checked
// against a local subset-simulation model of the transition table. Both
// channels idle and stall at random, and one phase holds off the receiver
// for a long stretch.
// ----------------------------------------------------------------------------
module tb_nfa_word_acceptor_unit;
  import nwa_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1025;
  localparam int PHASE_ITEMS  = 100;
  localparam int HOLD_CYCLES  = 300;
  localparam int TAIL_CYCLES  = 40;
  localparam int DIR_ROWS     = 25;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    symbol_t           sym;
    state_idx_t        src;
    state_idx_t        dst;
  } cmd_t;

  typedef struct packed {
    state_set_t active;
    logic       acc;
    logic       dead;
  } report_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    logic [FUNC_W-1:0] func;
    symbol_t           sym;
    state_idx_t        src;
    state_idx_t        dst;
    logic              typed;
    state_set_t        x_set;
    logic              x_acc;
    logic              x_dead;
    state_idx_t        cfg_init;
    state_set_t        cfg_mask;
  } dir_row_t;

  localparam dir_row_t DIR_TBL [DIR_ROWS] = '{
    '{ROW_ITEM, FUNC_UNUSED, 8'h00, 4'h0, 4'h0, 1'b1, 16'h0001, 1'b0, 1'b0, 4'h0, 16'h0000},
    '{ROW_ITEM, FUNC_SYMBOL, 8'h00, 4'h0, 4'h0, 1'b1, 16'h0000, 1'b0, 1'b1, 4'h0, 16'h0000},
    '{ROW_ITEM, FUNC_START,  8'hFF, 4'hF, 4'hF, 1'b1, 16'h0001, 1'b0, 1'b0, 4'h0, 16'h0000},
    '{ROW_ITEM, FUNC_ADD,    8'h00, 4'h0, 4'hF, 1'b1, 16'h0001, 1'b0, 1'b0, 4'h0, 16'h0000},
    '{ROW_ITEM, FUNC_ADD,    8'hFF, 4'hF, 4'h0, 1'b1, 16'h0001, 1'b0, 1'b0, 4'h0, 16'h0000},
    '{ROW_ITEM, FUNC_ADD,    8'hFF, 4'hF, 4'h0, 1'b1, 16'h0001, 1'b0, 1'b0, 4'h0, 16'h0000},
    '{ROW_ITEM, FUNC_ADD,    8'h00, 4'h0, 4'h0, 1'b1, 16'h0001, 1'b0, 1'b0, 4'h0, 16'h0000},
    '{ROW_ITEM, FUNC_SYMBOL, 8'h00, 4'h0, 4'h0, 1'b0, 16'h0000, 1'b0, 1'b0, 4'h0, 16'h0000},
    '{ROW_ITEM, FUNC_SYMBOL, 8'hFF, 4'h0, 4'h0, 1'b0, 16'h0000, 1'b0, 1'b0, 4'h0, 16'h0000},
    '{ROW_ITEM, FUNC_ADD,    8'h5A, 4'h0, 4'h7, 1'b1, 16'h0001, 1'b0, 1'b0, 4'h0, 16'h0000},
    '{ROW_ITEM, FUNC_ADD,    8'h5A, 4'h7, 4'h8, 1'b1, 16'h0001, 1'b0, 1'b0, 4'h0, 16'h0000},
    '{ROW_ITEM, FUNC_ADD,    8'hA5, 4'h8, 4'hF, 1'b1, 16'h0001, 1'b0, 1'b0, 4'h0, 16'h0000},
    '{ROW_ITEM, FUNC_SYMBOL, 8'h5A, 4'h0, 4'h0, 1'b0, 16'h0000, 1'b0, 1'b0, 4'h0, 16'h0000},
    '{ROW_ITEM, FUNC_SYMBOL, 8'h5A, 4'h0, 4'h0, 1'b0, 16'h0000, 1'b0, 1'b0, 4'h0, 16'h0000},
    '{ROW_ITEM, FUNC_UNUSED, 8'hFF, 4'hF, 4'hF, 1'b0, 16'h0000, 1'b0, 1'b0, 4'h0, 16'h0000},
    '{ROW_ITEM, FUNC_SYMBOL, 8'hA5, 4'h0, 4'h0, 1'b0, 16'h0000, 1'b0, 1'b0, 4'h0, 16'h0000},
    '{ROW_ITEM, FUNC_SYMBOL, 8'h00, 4'h0, 4'h0, 1'b0, 16'h0000, 1'b0, 1'b0, 4'h0, 16'h0000},
    '{ROW_ITEM, FUNC_SYMBOL, 8'h5A, 4'h0, 4'h0, 1'b0, 16'h0000, 1'b0, 1'b0, 4'h0, 16'h0000},
    '{ROW_CFG,  FUNC_UNUSED, 8'h00, 4'h0, 4'h0, 1'b0, 16'h0000, 1'b0, 1'b0, 4'hF, 16'hFFFF},
    '{ROW_ITEM, FUNC_START,  8'h00, 4'h0, 4'h0, 1'b1, 16'h8000, 1'b1, 1'b0, 4'h0, 16'h0000},
    '{ROW_ITEM, FUNC_SYMBOL, 8'hFF, 4'h0, 4'h0, 1'b0, 16'h0000, 1'b0, 1'b0, 4'h0, 16'h0000},
    '{ROW_ITEM, FUNC_SYMBOL, 8'h00, 4'h0, 4'h0, 1'b0, 16'h0000, 1'b0, 1'b0, 4'h0, 16'h0000},
    '{ROW_CFG,  FUNC_UNUSED, 8'h00, 4'h0, 4'h0, 1'b0, 16'h0000, 1'b0, 1'b0, 4'h0, 16'h0000},
    '{ROW_ITEM, FUNC_SYMBOL, 8'h00, 4'h0, 4'h0, 1'b0, 16'h0000, 1'b0, 1'b0, 4'h0, 16'h0000},
    '{ROW_ITEM, FUNC_START,  8'h00, 4'h0, 4'h0, 1'b1, 16'h0001, 1'b0, 1'b0, 4'h0, 16'h0000}
  };

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [FUNC_W-1:0]     in_func;
  symbol_t               in_symbol;
  state_idx_t            in_src;
  state_idx_t            in_dst;
  logic                  out_valid;
  logic                  out_stall;
  state_set_t            out_active_set;
  logic                  out_accepted;
  logic                  out_dead;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  nfa_word_acceptor_unit uut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .in_func_i         (in_func),
    .in_symbol_i       (in_symbol),
    .in_source_state_i (in_src),
    .in_dest_state_i   (in_dst),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .out_active_set_o  (out_active_set),
    .out_accepted_o    (out_accepted),
    .out_dead_o        (out_dead),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data)
  );

  // automaton model state
  state_set_t nfa_rows [TABLE_DEPTH];
  state_set_t live_set;
  state_idx_t start_reg;
  state_set_t accept_mask;

  report_t pending_reports [$];

  int  errors;
  int  n_cmds, n_add, n_start, n_sym, n_other;
  int  n_checked, n_acc_hits, n_dead_hits, n_cfg_writes, n_phases;
  bit  no_idle;
  bit  burst_send;
  bit  hold_req;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  task automatic step_automaton(input cmd_t c, output report_t r);
    state_set_t nxt;
    nxt = '0;
    case (c.func)
      FUNC_ADD:    nfa_rows[{c.src, c.sym}][c.dst] = 1'b1;
      FUNC_START:  live_set = state_set_t'(1) << start_reg;
      FUNC_SYMBOL: begin
        for (int s = 0; s < NUM_STATES; s++) begin
          if (live_set[s]) begin
            nxt |= nfa_rows[{state_idx_t'(s), c.sym}];
          end
        end
        live_set = nxt;
      end
      default: ;
    endcase
    r.active = live_set;
    r.acc    = (live_set & accept_mask) != '0;
    r.dead   = live_set == '0;
  endtask

  task automatic send_cmd(input cmd_t c, input logic use_typed, input report_t typed_rep);
    int      gap;
    report_t r;
    gap = (no_idle || burst_send) ? 0 : $urandom_range(0, 8);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid  <= 1'b1;
    in_func   <= c.func;
    in_symbol <= c.sym;
    in_src    <= c.src;
    in_dst    <= c.dst;
    do @(posedge clk); while (in_stall);
    step_automaton(c, r);
    pending_reports.insert(pending_reports.size(), use_typed ? typed_rep : r);
    n_cmds++;
    case (c.func)
      FUNC_ADD:    n_add++;
      FUNC_START:  n_start++;
      FUNC_SYMBOL: n_sym++;
      default:     n_other++;
    endcase
  endtask

  task automatic drain_reports();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_INITIAL_STATE) begin
      start_reg = data[STATE_W-1:0];
    end else begin
      accept_mask = data;
    end
    n_cfg_writes++;
  endtask

  task automatic run_phase(input int phase, input int budget, inout int sent);
    symbol_t    pool [4];
    state_idx_t walk;
    cmd_t       c;
    int         n_adds, k, sel;
    logic [CFG_DATA_W-1:0] d;
    drain_reports();
    no_idle    = (phase % 4) == 3;
    burst_send = phase == 2;
    if (phase == 0) begin
      write_reg(CFG_INITIAL_STATE, 16'h0000);
      write_reg(CFG_FINAL_MASK, 16'hFFFF);
    end else if (phase == 1) begin
      write_reg(CFG_INITIAL_STATE, 16'hFFFF);
      write_reg(CFG_FINAL_MASK, 16'h0000);
    end else begin
      if ($urandom_range(0, 3) != 0) begin
        write_reg(CFG_INITIAL_STATE, CFG_DATA_W'($urandom));
      end
      if ($urandom_range(0, 3) != 0) begin
        sel = $urandom_range(0, 2);
        d = (sel == 0) ? (state_set_t'(1) << $urandom_range(0, 15))
                       : CFG_DATA_W'($urandom);
        write_reg(CFG_FINAL_MASK, d);
      end
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (phase == 2) begin
      hold_req = 1'b1;
    end
    n_phases++;
    foreach (pool[i]) pool[i] = symbol_t'($urandom_range(0, 255));
    // grow a path from the start state, then scatter edges
    walk   = start_reg;
    n_adds = $urandom_range(10, 24);
    for (int i = 0; i < n_adds && sent < budget; i++) begin
      c.func = FUNC_ADD;
      c.sym  = pool[$urandom_range(0, 3)];
      c.src  = $urandom_range(0, 1) ? walk : state_idx_t'($urandom_range(0, 15));
      c.dst  = state_idx_t'($urandom_range(0, 15));
      walk   = c.dst;
      send_cmd(c, 1'b0, '0);
      sent++;
    end
    while (sent < budget) begin
      sel = $urandom_range(0, 99);
      if (sel < 10) begin
        c.func = FUNC_W'($urandom_range(0, 3));
        c.sym  = symbol_t'($urandom_range(0, 255));
        c.src  = state_idx_t'($urandom_range(0, 15));
        c.dst  = state_idx_t'($urandom_range(0, 15));
        send_cmd(c, 1'b0, '0);
        sent++;
      end else if (sel < 15) begin
        c.func = FUNC_ADD;
        c.sym  = pool[$urandom_range(0, 3)];
        c.src  = state_idx_t'($urandom_range(0, 15));
        c.dst  = state_idx_t'($urandom_range(0, 15));
        send_cmd(c, 1'b0, '0);
        sent++;
      end else begin
        c.func = FUNC_START;
        c.sym  = symbol_t'($urandom_range(0, 255));
        c.src  = state_idx_t'($urandom_range(0, 15));
        c.dst  = state_idx_t'($urandom_range(0, 15));
        send_cmd(c, 1'b0, '0);
        sent++;
        k = $urandom_range(1, 10);
        for (int j = 0; j < k; j++) begin
          c.func = FUNC_SYMBOL;
          c.sym  = ($urandom_range(0, 9) == 0) ? symbol_t'($urandom_range(0, 255))
                                               : pool[$urandom_range(0, 3)];
          c.src  = state_idx_t'($urandom_range(0, 15));
          c.dst  = state_idx_t'($urandom_range(0, 15));
          send_cmd(c, 1'b0, '0);
          sent++;
        end
      end
    end
    burst_send = 1'b0;
  endtask

  // result side: random stall, one long hold-off on request, check each transaction
  initial begin : report_sink
    int      w;
    report_t x;
    out_stall <= 1'b0;
    forever begin
      if (hold_req) begin
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        w = no_idle ? 0 : $urandom_range(0, 8);
        repeat (w) begin
          @(negedge clk);
          out_stall <= 1'b1;
        end
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      if (pending_reports.size() == 0) begin
        $error("unexpected result transaction: active_set %h", out_active_set);
        errors++;
      end else begin
        x = pending_reports.pop_front();
        n_checked++;
        if (x.acc) n_acc_hits++;
        if (x.dead) n_dead_hits++;
        if (out_active_set !== x.active) begin
          $error("active_set mismatch: expected %h, got %h", x.active, out_active_set);
          errors++;
        end
        if (out_accepted !== x.acc) begin
          $error("accepted mismatch: expected %b, got %b", x.acc, out_accepted);
          errors++;
        end
        if (out_dead !== x.dead) begin
          $error("dead mismatch: expected %b, got %b", x.dead, out_dead);
          errors++;
        end
      end
    end
  end

  initial begin : cmd_source
    cmd_t    c;
    report_t t;
    int      sent, phase;
    clk        = 1'b0;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_func    = FUNC_ADD;
    in_symbol  = '0;
    in_src     = '0;
    in_dst     = '0;
    cfg_valid  = 1'b0;
    cfg_index  = CFG_INITIAL_STATE;
    cfg_data   = '0;
    errors     = 0;
    n_cmds = 0; n_add = 0; n_start = 0; n_sym = 0; n_other = 0;
    n_checked = 0; n_acc_hits = 0; n_dead_hits = 0; n_cfg_writes = 0; n_phases = 0;
    no_idle    = 1'b0;
    burst_send = 1'b0;
    hold_req   = 1'b0;
    for (int i = 0; i < TABLE_DEPTH; i++) nfa_rows[i] = '0;
    live_set    = state_set_t'(1);
    start_reg   = '0;
    accept_mask = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    foreach (DIR_TBL[i]) begin
      if (DIR_TBL[i].kind == ROW_CFG) begin
        drain_reports();
        write_reg(CFG_INITIAL_STATE, {12'h000, DIR_TBL[i].cfg_init});
        write_reg(CFG_FINAL_MASK, DIR_TBL[i].cfg_mask);
        @(negedge clk);
        cfg_valid <= 1'b0;
      end else begin
        c.func   = DIR_TBL[i].func;
        c.sym    = DIR_TBL[i].sym;
        c.src    = DIR_TBL[i].src;
        c.dst    = DIR_TBL[i].dst;
        t.active = DIR_TBL[i].x_set;
        t.acc    = DIR_TBL[i].x_acc;
        t.dead   = DIR_TBL[i].x_dead;
        send_cmd(c, DIR_TBL[i].typed, t);
      end
    end

    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      run_phase(phase, (sent + PHASE_ITEMS < RANDOM_ITEMS) ? sent + PHASE_ITEMS
                                                           : RANDOM_ITEMS, sent);
      phase++;
    end

    drain_reports();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d commands: %0d add, %0d start, %0d symbol, %0d unused, %0d phases",
             n_cmds, n_add, n_start, n_sym, n_other, n_phases);
    $display("checked %0d results (%0d accepting, %0d empty) over %0d register writes",
             n_checked, n_acc_hits, n_dead_hits, n_cfg_writes);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> nfa_word_acceptor_unit.f
rtl/core/nwa_pkg.sv
rtl/core/nwa_ram.sv
rtl/core/nwa_ctrl.sv
rtl/core/nwa_dpath.sv
rtl/core/nfa_word_acceptor_unit.sv
bench/tb_nfa_word_acceptor_unit.sv
